@@ src/msq_pkg.sv @@
// Shared types, constants and edge tables for the marching squares segment extractor.
package msq_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DIM_RESET      = 1024;
    localparam int DIM_MIN        = 2;

    localparam int COORD_W  = 11;
    localparam int CASE_W   = 4;
    localparam int CFG_W    = 11;
    localparam int CFG_AW   = 1;
    localparam int IN_DW    = 8;
    localparam int OUT_DW   = 48;
    localparam int OUT_UW   = 4;

    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CASE_W-1:0] CASE_EMPTY    = 4'd0;
    localparam logic [CASE_W-1:0] CASE_SADDLE_A = 4'd6;
    localparam logic [CASE_W-1:0] CASE_SADDLE_B = 4'd9;
    localparam logic [CASE_W-1:0] CASE_FULL     = 4'd15;

    typedef enum logic [1:0] {
        EDGE_BOTTOM = 2'd0,
        EDGE_LEFT   = 2'd1,
        EDGE_RIGHT  = 2'd2,
        EDGE_TOP    = 2'd3
    } edge_t;

    typedef struct packed {
        edge_t s;
        edge_t e;
    } seg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic               valid;
        logic [CASE_W-1:0]  cell_case;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
    } cell_t;

    function automatic logic is_saddle(input logic [CASE_W-1:0] cs);
        return (cs == CASE_SADDLE_A) || (cs == CASE_SADDLE_B);
    endfunction

    // Edge pair of a case; second selects the later segment of a saddle.
    function automatic seg_t seg_edges(input logic [CASE_W-1:0] cs, input logic second);
        seg_t sg;
        sg = '{s: EDGE_BOTTOM, e: EDGE_LEFT};
        case (cs) inside
            4'd1, 4'd14: sg = '{s: EDGE_BOTTOM, e: EDGE_LEFT};
            4'd2, 4'd13: sg = '{s: EDGE_BOTTOM, e: EDGE_RIGHT};
            4'd3, 4'd12: sg = '{s: EDGE_LEFT,   e: EDGE_RIGHT};
            4'd4, 4'd11: sg = '{s: EDGE_LEFT,   e: EDGE_TOP};
            4'd5, 4'd10: sg = '{s: EDGE_BOTTOM, e: EDGE_TOP};
            4'd7, 4'd8:  sg = '{s: EDGE_RIGHT,  e: EDGE_TOP};
            4'd6:  sg = second ? seg_t'{s: EDGE_BOTTOM, e: EDGE_LEFT}
                               : seg_t'{s: EDGE_RIGHT,  e: EDGE_TOP};
            4'd9:  sg = second ? seg_t'{s: EDGE_BOTTOM, e: EDGE_RIGHT}
                               : seg_t'{s: EDGE_LEFT,   e: EDGE_TOP};
            default: sg = '{s: EDGE_BOTTOM, e: EDGE_LEFT};
        endcase
        return sg;
    endfunction

    // bx and by are the doubled lower-left corner, always even.
    function automatic point_t edge_point(input edge_t ed, input logic [COORD_W-1:0] bx,
                                          input logic [COORD_W-1:0] by);
        point_t p;
        case (ed)
            EDGE_BOTTOM: p = '{x: {bx[COORD_W-1:1], 1'b1}, y: by};
            EDGE_LEFT:   p = '{x: bx, y: {by[COORD_W-1:1], 1'b1}};
            EDGE_RIGHT:  p = '{x: bx + COORD_W'(2), y: {by[COORD_W-1:1], 1'b1}};
            EDGE_TOP:    p = '{x: {bx[COORD_W-1:1], 1'b1}, y: by + COORD_W'(2)};
            default:     p = '{x: bx, y: by};
        endcase
        return p;
    endfunction

endpackage

@@ src/marching_squares_segment_extractor_top.sv @@
// Marching squares segment extractor: pixel stream in, contour segment stream out.
// Latency: a segment is offered in the cycle after the transfer of the pixel closing its cell.
// Throughput: one pixel per cycle while the output is ready; a saddle cell holds the input
// until its first segment is taken, as both leave through the single output register.
// Reset: geometry to 1024 x 1024 (bounded by the maximums), counters cleared; the line
// memory is not cleared, its rows are rewritten before they are read.
module marching_squares_segment_extractor_top #(
    parameter int MAX_WIDTH  = msq_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = msq_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [msq_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [msq_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [msq_pkg::IN_DW-1:0]     s_axis_tdata,   // [0] pixel_set
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [10:0] start_x2, [21:11] start_y2, [32:22] end_x2, [43:33] end_y2
    output logic [msq_pkg::OUT_DW-1:0]    m_axis_tdata,
    output logic [msq_pkg::OUT_UW-1:0]    m_axis_tuser,   // [3:0] cell_case
    output logic                          m_axis_tlast    // last_of_item
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic           accept;
    logic           free;
    logic           above_bit;
    logic           mem_we;
    logic [CW-1:0]  mem_waddr;
    logic [CW-1:0]  mem_raddr;
    msq_pkg::cell_t cell_info;

    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;

    msq_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_axis_tdata[0]),
        .raddr (mem_raddr),
        .rdata (above_bit)
    );

    msq_cell_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW)
    ) u_cell_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .pixel     (s_axis_tdata[0]),
        .above_bit (above_bit),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_raddr (mem_raddr),
        .cell_info (cell_info)
    );

    msq_seg_emit u_seg_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && cell_info.valid),
        .cell_info (cell_info),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    a_no_empty_case: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != msq_pkg::CASE_EMPTY)
                          && (m_axis_tuser != msq_pkg::CASE_FULL))
        else $error("segment offered for an empty or full cell");

    a_first_is_saddle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (m_axis_tuser == msq_pkg::CASE_SADDLE_A) || (m_axis_tuser == msq_pkg::CASE_SADDLE_B))
        else $error("non-final segment from a non-saddle cell");

    a_hold_input_on_saddle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("pixel accepted while first saddle segment pending");

    a_saddle_second: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && m_axis_tlast && $stable(m_axis_tuser)))
        else $error("saddle second segment missing");

endmodule

@@ src/msq_line_mem.sv @@
// Single-bit line memory holding the previous row, registered read.
module msq_line_mem #(
    parameter int DEPTH = msq_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/msq_cell_unit.sv @@
// Geometry registers, raster counters and cell index formation.
module msq_cell_unit #(
    parameter int MAX_WIDTH  = msq_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = msq_pkg::DEF_MAX_HEIGHT,
    parameter int CW         = $clog2(MAX_WIDTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [msq_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [msq_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          accept,
    input  logic                          pixel,
    input  logic                          above_bit,
    output logic                          mem_we,
    output logic [CW-1:0]                 mem_waddr,
    output logic [CW-1:0]                 mem_raddr,
    output msq_pkg::cell_t                cell_info
);

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (CW > msq_pkg::COORD_W) ? CW : msq_pkg::COORD_W;
    localparam int YW = (HW > msq_pkg::COORD_W) ? HW : msq_pkg::COORD_W;
    localparam int W_RST = (msq_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : msq_pkg::DIM_RESET;
    localparam int H_RST = (msq_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : msq_pkg::DIM_RESET;

    logic [WW-1:0] width_reg,  width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [CW-1:0] col_reg,    col_next;
    logic [RW-1:0] row_reg,    row_next;
    logic          left_reg,   left_next;
    logic          upleft_reg;

    logic          row_end;
    logic          frame_end;
    logic [XW-1:0] x_ext;
    logic [YW-1:0] y_ext;
    logic [msq_pkg::CASE_W-1:0] cs;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                msq_pkg::REG_IMAGE_WIDTH:
                begin
                    if (cfg_wdata < msq_pkg::CFG_W'(msq_pkg::DIM_MIN))
                        width_next = WW'(msq_pkg::DIM_MIN);
                    else if (32'(cfg_wdata) > MAX_WIDTH)
                        width_next = WW'(MAX_WIDTH);
                    else
                        width_next = WW'(cfg_wdata);
                end
                msq_pkg::REG_IMAGE_HEIGHT:
                begin
                    if (cfg_wdata < msq_pkg::CFG_W'(msq_pkg::DIM_MIN))
                        height_next = HW'(msq_pkg::DIM_MIN);
                    else if (32'(cfg_wdata) > MAX_HEIGHT)
                        height_next = HW'(MAX_HEIGHT);
                    else
                        height_next = HW'(cfg_wdata);
                end
                default: ;
            endcase
        end
    end

    assign row_end   = (WW'(col_reg) == width_reg - WW'(1));
    assign frame_end = row_end && (HW'(row_reg) == height_reg - HW'(1));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (cfg_we)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = 1'b0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                col_next  = '0;
                row_next  = '0;
                left_next = 1'b0;
            end
            else if (row_end)
            begin
                col_next  = '0;
                row_next  = row_reg + RW'(1);
                left_next = 1'b0;
            end
            else
            begin
                col_next  = col_reg + CW'(1);
                left_next = pixel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(H_RST);
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
        end
    end

    // Upper-right bit of this cell becomes the upper-left bit of the next one.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upleft_reg <= above_bit;
        end
    end

    // Read runs one column ahead so the upper-right bit is ready at transfer.
    assign mem_raddr = col_next;
    assign mem_we    = accept;
    assign mem_waddr = col_reg;

    assign cs    = {above_bit, upleft_reg, pixel, left_reg};
    assign x_ext = XW'(col_reg) - XW'(1);
    assign y_ext = YW'(height_reg) - YW'(1) - YW'(row_reg);

    always_comb
    begin
        cell_info.valid     = (col_reg != '0) && (row_reg != '0)
                              && (cs != msq_pkg::CASE_EMPTY) && (cs != msq_pkg::CASE_FULL);
        cell_info.cell_case = cs;
        cell_info.x2        = {x_ext[msq_pkg::COORD_W-2:0], 1'b0};
        cell_info.y2        = {y_ext[msq_pkg::COORD_W-2:0], 1'b0};
    end

endmodule

@@ src/msq_seg_emit.sv @@
// Output register for one cell; sends its one or two segments in order.
module msq_seg_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  msq_pkg::cell_t                cell_info,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [msq_pkg::OUT_DW-1:0]    out_data,
    output logic [msq_pkg::OUT_UW-1:0]    out_user,
    output logic                          out_last
);

    logic           valid_reg,  valid_next;
    logic           phase_reg,  phase_next;
    msq_pkg::cell_t rec_reg;

    logic           last_seg;
    logic           xfer;
    msq_pkg::seg_t  seg;
    msq_pkg::point_t p_start;
    msq_pkg::point_t p_end;

    assign last_seg = !msq_pkg::is_saddle(rec_reg.cell_case) || phase_reg;
    assign xfer     = valid_reg && out_ready;
    assign free     = !valid_reg || (out_ready && last_seg);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
        end
        else if (xfer && last_seg)
        begin
            valid_next = 1'b0;
            phase_next = 1'b0;
        end
        else if (xfer)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= cell_info;
        end
    end

    assign seg     = msq_pkg::seg_edges(rec_reg.cell_case, phase_reg);
    assign p_start = msq_pkg::edge_point(seg.s, rec_reg.x2, rec_reg.y2);
    assign p_end   = msq_pkg::edge_point(seg.e, rec_reg.x2, rec_reg.y2);

    assign out_valid = valid_reg;
    assign out_last  = last_seg;
    assign out_user  = rec_reg.cell_case;
    assign out_data  = {4'b0, p_end.y, p_end.x, p_start.y, p_start.x};

endmodule
